/* sv/fpdc_pkg.sv */
// Shared types and constants for the fractional PLL divider calculator.
// Used by fpdc_divider and fractional_pll_divider_calc_core; no dependencies.
`default_nettype none

package fpdc_pkg;

   localparam int FREQ_W     = 22;
   localparam int XTAL_W     = 15;
   localparam int VCO_W      = 27;
   localparam int DIVIDEND_W = VCO_W - 1;
   localparam int NINT_W     = 8;
   localparam int FRA_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [VCO_W-1:0] VCO_MIN_KHZ = 27'd2350000;
   localparam logic [VCO_W-1:0] VCO_MAX_KHZ = 27'd4700000;

   localparam logic [XTAL_W-1:0] XTAL_RESET_KHZ = 15'd24000;

   localparam logic [CSR_IDX_W-1:0] CSR_XTAL_KHZ     = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHIP_VARIANT = 4'd1;

   // Sigma-delta halving loop
   localparam int                 SDM_STEPS  = 15;
   localparam logic [FRA_W-1:0]   SDM_WEIGHT = 16'h8000;

   // Register byte masks and mode bits
   localparam logic [BYTE_W-1:0] R4_KEEP_MASK   = 8'hfe;
   localparam logic [BYTE_W-1:0] R4_MODE_MASK   = 8'h3f;
   localparam logic [BYTE_W-1:0] R4_MODE_LOW    = 8'h40;
   localparam logic [BYTE_W-1:0] R4_MODE_HIGH   = 8'h80;
   localparam logic [BYTE_W-1:0] R4_INT_ONLY    = 8'h02;
   localparam logic [BYTE_W-1:0] R8_KEEP_MASK   = 8'hef;
   localparam logic [BYTE_W-1:0] R12_BIT4       = 8'h10;
   localparam logic [BYTE_W-1:0] R12_CLEAR_MASK = 8'hef;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [XTAL_W-1:0]     divisor;
   } fpdc_div_cmd_type;

   typedef struct packed {
      logic              done;
      logic [NINT_W-1:0] quot;
   } fpdc_div_status_type;

endpackage

`default_nettype wire

/* sv/fpdc_divider.sv */
// Serial restoring divider, one quotient bit per cycle; keeps the low quotient byte.
// Depends on fpdc_pkg.
`default_nettype none

module fpdc_divider (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire fpdc_pkg::fpdc_div_cmd_type cmd,
   output fpdc_pkg::fpdc_div_status_type   status
);
   import fpdc_pkg::*;

   localparam int CNT_W = $clog2(DIVIDEND_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [XTAL_W-1:0]     dsr_ff, dsr_in;
   logic [XTAL_W-1:0]     rem_ff, rem_in;
   logic [NINT_W-1:0]     quot_ff, quot_in;

   logic [XTAL_W:0] shifted;
   logic [XTAL_W:0] diff;
   logic            fits;

   always_comb begin
      shifted = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      fits    = (shifted >= {1'b0, dsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = cmd.dividend;
         dsr_in  = cmd.divisor;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         // a zero divisor always fits, so every quotient bit comes out set
         rem_in  = fits ? diff[XTAL_W-1:0] : shifted[XTAL_W-1:0];
         quot_in = {quot_ff[NINT_W-2:0], fits};
         dvd_in  = {dvd_ff[DIVIDEND_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign status.done = done_ff;
   assign status.quot = quot_ff;

endmodule

`default_nettype wire

/* sv/fractional_pll_divider_calc_core.sv */
// Top level of the fractional PLL divider calculator: sequencer, snap and sigma-delta loop.
// Depends on fpdc_pkg and fpdc_divider.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    freq_khz, prior_reg4/8/12
//   rsp      out        rsp_valid/rsp_ready    new_reg4..new_reg8, new_reg12
//   csr      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// An item passes from acceptance to its result through one setup step, the serial divider
// (26 quotient bits and the done flag), one step each for multiply, fraction and snap, up
// to SDM_STEPS sigma-delta halving steps and one output step. req_ready is high only while
// the sequencer is idle.
// A result waits in the output register until taken; the next item may run meanwhile,
// and holds at its last step until the output register is free.
// Reset is synchronous: crystal returns to 24000 kHz, variant to 0, no result pending.
`default_nettype none

module fractional_pll_divider_calc_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [fpdc_pkg::FREQ_W-1:0]     req_freq_khz,
   input  wire logic [fpdc_pkg::BYTE_W-1:0]     req_prior_reg4,
   input  wire logic [fpdc_pkg::BYTE_W-1:0]     req_prior_reg8,
   input  wire logic [fpdc_pkg::BYTE_W-1:0]     req_prior_reg12,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic [fpdc_pkg::BYTE_W-1:0]          rsp_new_reg4,
   output logic [fpdc_pkg::BYTE_W-1:0]          rsp_new_reg5,
   output logic [fpdc_pkg::BYTE_W-1:0]          rsp_new_reg6,
   output logic [fpdc_pkg::BYTE_W-1:0]          rsp_new_reg7,
   output logic [fpdc_pkg::BYTE_W-1:0]          rsp_new_reg8,
   output logic [fpdc_pkg::BYTE_W-1:0]          rsp_new_reg12,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [fpdc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fpdc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fpdc_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SETUP  = 3'd1;
   localparam logic [2:0] ST_DIVIDE = 3'd2;
   localparam logic [2:0] ST_MULT   = 3'd3;
   localparam logic [2:0] ST_FRAC   = 3'd4;
   localparam logic [2:0] ST_SNAP   = 3'd5;
   localparam logic [2:0] ST_SDM    = 3'd6;
   localparam logic [2:0] ST_DONE   = 3'd7;

   localparam int SDM_CNT_W = $clog2(SDM_STEPS);
   localparam logic [SDM_CNT_W-1:0] SDM_LAST = SDM_CNT_W'(SDM_STEPS - 1);
   localparam int PROD_W = XTAL_W + NINT_W;

   logic [2:0]           state_ff, state_in;
   logic [XTAL_W-1:0]    xtal_ff, xtal_in;
   logic                 variant_ff, variant_in;
   logic [FREQ_W-1:0]    freq_ff, freq_in;
   logic [BYTE_W-1:0]    r4_ff, r4_in, r8_ff, r8_in, r12_ff, r12_in;
   logic [VCO_W-1:0]     vco_ff, vco_in;
   logic [1:0]           code_ff, code_in;
   logic [NINT_W-1:0]    nint_ff, nint_in;
   logic [FRA_W-1:0]     prod_ff, prod_in;
   logic [FRA_W-1:0]     fra_ff, fra_in;
   logic                 fra_zero_ff, fra_zero_in;
   logic [FRA_W-1:0]     step_ff, step_in;
   logic [FRA_W-1:0]     weight_ff, weight_in;
   logic [FRA_W-1:0]     sdm_ff, sdm_in;
   logic [SDM_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]    o4_ff, o4_in, o5_ff, o5_in, o6_ff, o6_in;
   logic [BYTE_W-1:0]    o7_ff, o7_in, o8_ff, o8_in, o12_ff, o12_in;

   fpdc_div_cmd_type    div_cmd;
   fpdc_div_status_type div_stat;

   // mixer divider search, all five candidates side by side
   logic [VCO_W-1:0] vco_d2, vco_d4, vco_d8, vco_d16, vco_d32;
   logic             fit_d2, fit_d4, fit_d8, fit_d16;

   // snap thresholds
   logic [XTAL_W+6:0] x127;
   logic [XTAL_W+7:0] x129;
   logic [FRA_W-1:0]  th_low, th_high, th_127, th_129, xtal16;

   logic [PROD_W-1:0] prod_full;
   logic [8:0]        d_signed;
   logic [8:0]        ni_q;
   logic [BYTE_W-1:0] b4, b8, b12, b5;

   fpdc_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .cmd    (div_cmd),
      .status (div_stat)
   );

   always_comb begin
      vco_d2  = VCO_W'(freq_ff) << 1;
      vco_d4  = VCO_W'(freq_ff) << 2;
      vco_d8  = VCO_W'(freq_ff) << 3;
      vco_d16 = VCO_W'(freq_ff) << 4;
      vco_d32 = VCO_W'(freq_ff) << 5;
      fit_d2  = (vco_d2 >= VCO_MIN_KHZ) && (vco_d2 <= VCO_MAX_KHZ);
      fit_d4  = (vco_d4 >= VCO_MIN_KHZ) && (vco_d4 <= VCO_MAX_KHZ);
      fit_d8  = (vco_d8 >= VCO_MIN_KHZ) && (vco_d8 <= VCO_MAX_KHZ);
      fit_d16 = (vco_d16 >= VCO_MIN_KHZ) && (vco_d16 <= VCO_MAX_KHZ);

      xtal16  = {1'b0, xtal_ff};
      x127    = {xtal_ff, 7'b0} - (XTAL_W+7)'(xtal_ff);
      x129    = {1'b0, xtal_ff, 7'b0} + (XTAL_W+8)'(xtal_ff);
      th_low  = FRA_W'(xtal_ff >> 6);
      th_high = x127[XTAL_W+6:6];
      th_127  = FRA_W'(x127[XTAL_W+6:7]);
      th_129  = x129[XTAL_W+7:7];

      prod_full = xtal_ff * nint_ff;

      // ni truncates toward zero; si keeps only its low two bits, equal to d's
      d_signed = {1'b0, nint_ff} - 9'd13;
      ni_q     = d_signed[8] ? 9'((d_signed + 9'd3) >> 2) | 9'h180
                             : 9'(d_signed >> 2);
      b5       = {d_signed[1:0], ni_q[5:0]};

      b4  = (r4_ff & R4_KEEP_MASK) | {7'b0, code_ff[0]};
      b8  = r8_ff;
      b12 = r12_ff;
      if (variant_ff) begin
         b8 = (r8_ff & R8_KEEP_MASK) | {3'b0, code_ff[1], 4'b0};
         b4 = b4 & R4_MODE_MASK;
         if (code_ff <= 2'd1) begin
            b4  = b4 | R4_MODE_LOW;
            b12 = r12_ff | R12_BIT4;
         end else begin
            b4  = b4 | R4_MODE_HIGH;
            b12 = r12_ff & R12_CLEAR_MASK;
         end
      end
      if (fra_zero_ff) begin
         b4 = b4 | R4_INT_ONLY;
      end

      state_in     = state_ff;
      xtal_in      = xtal_ff;
      variant_in   = variant_ff;
      freq_in      = freq_ff;
      r4_in        = r4_ff;
      r8_in        = r8_ff;
      r12_in       = r12_ff;
      vco_in       = vco_ff;
      code_in      = code_ff;
      nint_in      = nint_ff;
      prod_in      = prod_ff;
      fra_in       = fra_ff;
      fra_zero_in  = fra_zero_ff;
      step_in      = step_ff;
      weight_in    = weight_ff;
      sdm_in       = sdm_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      o4_in        = o4_ff;
      o5_in        = o5_ff;
      o6_in        = o6_ff;
      o7_in        = o7_ff;
      o8_in        = o8_ff;
      o12_in       = o12_ff;

      div_cmd.start    = 1'b0;
      div_cmd.dividend = vco_in[VCO_W-1:1];
      div_cmd.divisor  = xtal_ff;

      if (csr_valid) begin
         if (csr_index == CSR_XTAL_KHZ) begin
            xtal_in = csr_wdata[XTAL_W-1:0];
         end else if (csr_index == CSR_CHIP_VARIANT) begin
            variant_in = csr_wdata[0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               freq_in  = req_freq_khz;
               r4_in    = req_prior_reg4;
               r8_in    = req_prior_reg8;
               r12_in   = req_prior_reg12;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (fit_d2) begin
               vco_in  = vco_d2;
               code_in = 2'd1;
            end else if (fit_d4) begin
               vco_in  = vco_d4;
               code_in = 2'd0;
            end else if (fit_d8) begin
               vco_in  = vco_d8;
               code_in = 2'd2;
            end else if (fit_d16) begin
               vco_in  = vco_d16;
               code_in = 2'd3;
            end else begin
               vco_in  = vco_d32;
               code_in = 2'd0;
            end
            // divide the freshly chosen VCO value
            div_cmd.dividend = vco_in[VCO_W-1:1];
            div_cmd.start    = 1'b1;
            state_in         = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               nint_in  = div_stat.quot;
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = {prod_full[FRA_W-2:0], 1'b0};
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            fra_in   = vco_ff[FRA_W-1:0] - prod_ff;
            state_in = ST_SNAP;
         end
         ST_SNAP: begin
            if (fra_ff < th_low) begin
               fra_in = '0;
            end else if (fra_ff > th_high) begin
               fra_in  = '0;
               nint_in = nint_ff + 1'b1;
            end else if (fra_ff > th_127 && fra_ff < xtal16) begin
               fra_in = th_127;
            end else if (fra_ff > xtal16 && fra_ff < th_129) begin
               fra_in = th_129;
            end
            fra_zero_in = (fra_in == '0);
            step_in     = xtal16;
            weight_in   = SDM_WEIGHT;
            sdm_in      = '0;
            cnt_in      = '0;
            state_in    = ST_SDM;
         end
         ST_SDM: begin
            if (fra_ff <= 16'd1) begin
               state_in = ST_DONE;
            end else begin
               if (fra_ff > step_ff) begin
                  sdm_in = sdm_ff | weight_ff;
                  fra_in = fra_ff - step_ff;
               end
               step_in   = step_ff >> 1;
               weight_in = weight_ff >> 1;
               cnt_in    = cnt_ff + 1'b1;
               if (cnt_ff == SDM_LAST) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               o4_in        = b4;
               o5_in        = b5;
               o6_in        = sdm_ff[7:0];
               o7_in        = sdm_ff[15:8];
               o8_in        = b8;
               o12_in       = b12;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         xtal_ff      <= XTAL_RESET_KHZ;
         variant_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         xtal_ff      <= xtal_in;
         variant_ff   <= variant_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      freq_ff     <= freq_in;
      r4_ff       <= r4_in;
      r8_ff       <= r8_in;
      r12_ff      <= r12_in;
      vco_ff      <= vco_in;
      code_ff     <= code_in;
      nint_ff     <= nint_in;
      prod_ff     <= prod_in;
      fra_ff      <= fra_in;
      fra_zero_ff <= fra_zero_in;
      step_ff     <= step_in;
      weight_ff   <= weight_in;
      sdm_ff      <= sdm_in;
      cnt_ff      <= cnt_in;
      o4_ff       <= o4_in;
      o5_ff       <= o5_in;
      o6_ff       <= o6_in;
      o7_ff       <= o7_in;
      o8_ff       <= o8_in;
      o12_ff      <= o12_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_reg4  = o4_ff;
   assign rsp_new_reg5  = o5_ff;
   assign rsp_new_reg6  = o6_ff;
   assign rsp_new_reg7  = o7_ff;
   assign rsp_new_reg8  = o8_ff;
   assign rsp_new_reg12 = o12_ff;

`ifndef NO_ASSERTIONS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sequencer still idle after taking an item");

   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide step");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff) == ST_DONE)
      else $error("result raised without finishing an item");
`endif

endmodule

`default_nettype wire
